// ===== rtl/tevp_pkg.sv =====
// Shared types, constants and phase encoding for the event record parser.
// Used by every module of the parser; depends on nothing.
`default_nettype none

package tevp_pkg;

  localparam int MAX_RUNES = 256;
  localparam int RUNE_W    = (MAX_RUNES > 2) ? $clog2(MAX_RUNES) : 1;
  localparam int NUM_W     = 31;

  localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam int         RADIX    = 10;

  localparam logic [7:0] UTF_TWO   = 8'h80;
  localparam logic [7:0] UTF_THREE = 8'hE0;
  localparam logic [7:0] UTF_FOUR  = 8'hF0;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_TEXT   = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_CLOSED = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [1:0] ERR_BAD_NUMBER = 2'd0;
  localparam logic [1:0] ERR_COUNT_BIG  = 2'd1;
  localparam logic [1:0] ERR_EARLY_END  = 2'd2;
  localparam logic [1:0] ERR_NO_NEWLINE = 2'd3;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_SECOND,
    PH_START,
    PH_END,
    PH_FLAG,
    PH_COUNT,
    PH_LEAD,
    PH_CONT,
    PH_NEWLINE,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_end;
  } tevp_in_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [7:0]       origin_char;
    logic [7:0]       type_char;
    logic [NUM_W-1:0] start_pos;
    logic [NUM_W-1:0] end_pos;
    logic [NUM_W-1:0] flag_bits;
    logic [7:0]       rune_count;
    logic [7:0]       text_byte;
    logic             rune_done;
    logic [1:0]       error_code;
  } tevp_out_t;

  typedef struct packed {
    logic      valid;
    tevp_out_t data;
  } tevp_res_t;

endpackage

`default_nettype wire

// ===== rtl/tevp_parser.sv =====
// Record parser state machine: takes one accepted byte per cycle, updates
// the record registers and forms at most one result. Depends on tevp_pkg.
`default_nettype none

module tevp_parser import tevp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire tevp_in_t  item_data,
  output tevp_res_t      res
);

  phase_t            phase, phase_next;
  logic [7:0]        first_char, first_char_next;
  logic [7:0]        second_char, second_char_next;
  logic [NUM_W-1:0]  number_acc, number_acc_next;
  logic [NUM_W-1:0]  start_reg, start_reg_next;
  logic [NUM_W-1:0]  end_reg, end_reg_next;
  logic [NUM_W-1:0]  flag_reg, flag_reg_next;
  logic [RUNE_W-1:0] runes_left, runes_left_next;
  logic [1:0]        rune_bytes_left, rune_bytes_left_next;

  logic [7:0]        b;
  logic              fin;
  logic              is_digit;
  logic [NUM_W+3:0]  acc_wide;
  logic [NUM_W-1:0]  acc_sat;
  logic              count_big;
  logic [RUNE_W-1:0] runes_dec;
  logic [1:0]        bytes_dec;
  logic [1:0]        lead_len;

  assign b         = item_data.byte_in;
  assign fin       = item_data.stream_end;
  assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_wide  = ({3'b000, number_acc, 1'b0} + {number_acc, 3'b000})
                   + {(NUM_W + 4 - 8)'(0), b - CH_ZERO};
  assign acc_sat   = (acc_wide > {4'b0000, NUM_SAT}) ? NUM_SAT : acc_wide[NUM_W-1:0];
  assign count_big = number_acc >= NUM_W'(MAX_RUNES);
  assign runes_dec = (runes_left != '0) ? runes_left - RUNE_W'(1) : '0;
  assign bytes_dec = rune_bytes_left - 2'd1;
  assign lead_len  = (b < UTF_THREE) ? 2'd1 : (b < UTF_FOUR) ? 2'd2 : 2'd3;

  always_comb begin
    phase_next           = phase;
    first_char_next      = first_char;
    second_char_next     = second_char;
    number_acc_next      = number_acc;
    start_reg_next       = start_reg;
    end_reg_next         = end_reg;
    flag_reg_next        = flag_reg;
    runes_left_next      = runes_left;
    rune_bytes_left_next = rune_bytes_left;
    unique case (phase)
      PH_FIRST: begin
        if (fin) begin
          phase_next = PH_STOP;
        end else begin
          first_char_next = b;
          phase_next      = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (fin) begin
          phase_next = PH_STOP;
        end else begin
          second_char_next = b;
          number_acc_next  = '0;
          phase_next       = PH_START;
        end
      end
      PH_START, PH_END, PH_FLAG, PH_COUNT: begin
        if (fin) begin
          phase_next = PH_STOP;
        end else if (is_digit) begin
          number_acc_next = acc_sat;
        end else if (b != CH_SPACE) begin
          phase_next = PH_STOP;
        end else begin
          number_acc_next = '0;
          unique case (phase)
            PH_START: begin
              start_reg_next = number_acc;
              phase_next     = PH_END;
            end
            PH_END: begin
              end_reg_next = number_acc;
              phase_next   = PH_FLAG;
            end
            PH_FLAG: begin
              flag_reg_next = number_acc;
              phase_next    = PH_COUNT;
            end
            default: begin
              if (count_big) begin
                number_acc_next = number_acc;
                phase_next      = PH_STOP;
              end else begin
                runes_left_next = RUNE_W'(number_acc);
                phase_next      = (number_acc == '0) ? PH_NEWLINE : PH_LEAD;
              end
            end
          endcase
        end
      end
      PH_LEAD: begin
        if (fin) begin
          phase_next = PH_STOP;
        end else if (b < UTF_TWO) begin
          runes_left_next = runes_dec;
          phase_next      = (runes_dec == '0) ? PH_NEWLINE : PH_LEAD;
        end else begin
          rune_bytes_left_next = lead_len;
          phase_next           = PH_CONT;
        end
      end
      PH_CONT: begin
        if (fin) begin
          phase_next = PH_STOP;
        end else begin
          rune_bytes_left_next = bytes_dec;
          if (bytes_dec == 2'd0) begin
            runes_left_next = runes_dec;
            phase_next      = (runes_dec == '0) ? PH_NEWLINE : PH_LEAD;
          end
        end
      end
      PH_NEWLINE: begin
        phase_next = (fin || (b != CH_LF)) ? PH_STOP : PH_FIRST;
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  always_comb begin
    tevp_out_t rec;
    tevp_out_t blank;
    blank             = '0;
    rec               = '0;
    rec.origin_char   = first_char;
    rec.type_char     = second_char;
    rec.start_pos     = start_reg;
    rec.end_pos       = end_reg;
    rec.flag_bits     = flag_reg;
    rec.rune_count    = 8'(32'(runes_left));
    res.valid         = 1'b0;
    res.data          = blank;
    unique case (phase)
      PH_FIRST: begin
        if (fin) begin
          res.valid            = 1'b1;
          res.data.result_kind = KIND_CLOSED;
        end
      end
      PH_SECOND: begin
        if (fin) begin
          res.valid            = 1'b1;
          res.data.result_kind = KIND_ERROR;
          res.data.error_code  = ERR_BAD_NUMBER;
        end
      end
      PH_START, PH_END, PH_FLAG, PH_COUNT: begin
        if (fin || (!is_digit && (b != CH_SPACE))) begin
          res.valid            = 1'b1;
          res.data.result_kind = KIND_ERROR;
          res.data.error_code  = ERR_BAD_NUMBER;
        end else if (!is_digit && (phase == PH_COUNT)) begin
          res.valid = 1'b1;
          if (count_big) begin
            res.data.result_kind = KIND_ERROR;
            res.data.error_code  = ERR_COUNT_BIG;
          end else begin
            res.data             = rec;
            res.data.result_kind = KIND_HEADER;
            res.data.rune_count  = 8'(number_acc);
          end
        end
      end
      PH_LEAD, PH_CONT: begin
        res.valid = 1'b1;
        if (fin) begin
          res.data.result_kind = KIND_ERROR;
          res.data.error_code  = ERR_EARLY_END;
        end else begin
          res.data             = rec;
          res.data.result_kind = KIND_TEXT;
          res.data.text_byte   = b;
          res.data.rune_done   = (phase == PH_LEAD) ? (b < UTF_TWO) : (bytes_dec == 2'd0);
        end
      end
      PH_NEWLINE: begin
        res.valid = 1'b1;
        if (fin || (b != CH_LF)) begin
          res.data.result_kind = KIND_ERROR;
          res.data.error_code  = ERR_NO_NEWLINE;
        end else begin
          res.data             = rec;
          res.data.result_kind = KIND_END;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      first_char      <= '0;
      second_char     <= '0;
      number_acc      <= '0;
      start_reg       <= '0;
      end_reg         <= '0;
      flag_reg        <= '0;
      runes_left      <= '0;
      rune_bytes_left <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      first_char      <= first_char_next;
      second_char     <= second_char_next;
      number_acc      <= number_acc_next;
      start_reg       <= start_reg_next;
      end_reg         <= end_reg_next;
      flag_reg        <= flag_reg_next;
      runes_left      <= runes_left_next;
      rune_bytes_left <= rune_bytes_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tevp_out_reg.sv =====
// Result register: holds one finished result until the receiver takes it.
// Depends on tevp_pkg for the result types.
`default_nettype none

module tevp_out_reg import tevp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tevp_res_t res,
  output logic           space,
  output logic           result_valid,
  input  wire logic      result_ready,
  output tevp_out_t      result
);

  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result <= res.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_event_record_parser_core.sv =====
// Top level of the event record parser: byte input channel, result output
// channel. Depends on tevp_pkg, tevp_parser and tevp_out_reg.
//
// Usage:
// The item channel carries one stream byte per beat, or an end-of-stream
// mark. The result channel carries header, text byte, record end, stream
// closed and error results, at most one per input beat.
// A byte is taken in every cycle while the result register is empty or is
// being emptied in the same cycle, so throughput is one byte per cycle.
// A result appears on the result channel in the cycle after the byte that
// causes it is accepted. The parser state machine decides each byte in a
// single pass between its state registers and the result register. Reset
// clears the parser to wait for the first character of a record and
// empties the result register. When the receiver stalls, the pending result
// holds and item_ready drops until it is taken. After an error or a stream
// closed result the parser keeps taking beats but gives no results until
// the next reset.
`default_nettype none

module text_event_record_parser_core import tevp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire tevp_in_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output tevp_out_t     result
);

  tevp_res_t res;
  logic      fire;

  assign fire = item_valid && item_ready;

  tevp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item_data (item),
    .res       (res)
  );

  tevp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .space        (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/tevp_checker.sv =====
// Port-level checks for the event record parser, bound to the top level.
// Depends on tevp_pkg for result kind codes.
`default_nettype none

module tevp_checker import tevp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_ready,
  input wire logic      result_valid,
  input wire logic      result_ready,
  input wire tevp_out_t result
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without a stalled result");

  a_silent_after_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready
      && (result.result_kind == KIND_CLOSED || result.result_kind == KIND_ERROR)
      |=> !result_valid)
    else $error("result after the parser stopped");

  a_text_fields_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind != KIND_TEXT)
      |-> (result.text_byte == 8'd0) && !result.rune_done)
    else $error("text fields set on a non-text beat");

endmodule

bind text_event_record_parser_core tevp_checker u_tevp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

// ===== sim/text_event_record_parser_core_test.sv =====
// Self-checking testbench for text_event_record_parser_core: feeds event record byte streams
// and compares every result beat against an in-bench parser of the same record format.
// Depends on tevp_pkg and the parser RTL only.

module text_event_record_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tevp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  tevp_in_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  tevp_out_t result;

  text_event_record_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #6 clk = ~clk;

  phase_t           ph = PH_FIRST;
  logic [7:0]       rec_origin = '0;
  logic [7:0]       rec_type = '0;
  logic [NUM_W-1:0] digits_acc = '0;
  logic [NUM_W-1:0] rec_start = '0;
  logic [NUM_W-1:0] rec_end = '0;
  logic [NUM_W-1:0] rec_flags = '0;
  logic [NUM_W-1:0] runes_left = '0;
  logic [1:0]       rune_bytes_left = '0;

  tevp_out_t pending_results[$];
  tevp_out_t oldest_result;

  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned records_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          idle_enabled = 1'b1;
  int unsigned stall_clock = 0;
  int unsigned stall_mode = 0;
  int unsigned stop_case = 0;
  string       stop_names[8] = '{"close between records", "end after first character",
                                 "end inside a number", "bad number terminator",
                                 "count too large", "end inside text",
                                 "wrong byte for newline", "end before newline"};

  function automatic tevp_out_t record_fields(logic [2:0] kind);
    tevp_out_t r;
    r = '0;
    r.result_kind = kind;
    r.origin_char = rec_origin;
    r.type_char   = rec_type;
    r.start_pos   = rec_start;
    r.end_pos     = rec_end;
    r.flag_bits   = rec_flags;
    r.rune_count  = runes_left[7:0];
    return r;
  endfunction

  function automatic tevp_out_t parse_error(logic [1:0] code);
    tevp_out_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = code;
    ph = PH_STOP;
    return r;
  endfunction

  function automatic void finish_rune();
    if (runes_left != 0) runes_left = runes_left - 1'b1;
    ph = (runes_left == 0) ? PH_NEWLINE : PH_LEAD;
  endfunction

  function automatic void parse_byte(input tevp_in_t beat, output logic has_res,
                                     output tevp_out_t res);
    logic [7:0]  b;
    logic [34:0] wide;
    b = beat.byte_in;
    has_res = 1'b0;
    res = '0;
    case (ph)
      PH_FIRST: begin
        if (beat.stream_end) begin
          has_res = 1'b1;
          res.result_kind = KIND_CLOSED;
          ph = PH_STOP;
        end else begin
          rec_origin = b;
          ph = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (beat.stream_end) begin
          has_res = 1'b1;
          res = parse_error(ERR_BAD_NUMBER);
        end else begin
          rec_type = b;
          digits_acc = '0;
          ph = PH_START;
        end
      end
      PH_START, PH_END, PH_FLAG, PH_COUNT: begin
        if (beat.stream_end) begin
          has_res = 1'b1;
          res = parse_error(ERR_BAD_NUMBER);
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          wide = {4'b0, digits_acc} * RADIX + {27'b0, b - CH_ZERO};
          digits_acc = (wide > {4'b0, NUM_SAT}) ? NUM_SAT : wide[NUM_W-1:0];
        end else if (b != CH_SPACE) begin
          has_res = 1'b1;
          res = parse_error(ERR_BAD_NUMBER);
        end else if (ph == PH_COUNT) begin
          has_res = 1'b1;
          if (digits_acc >= MAX_RUNES) begin
            res = parse_error(ERR_COUNT_BIG);
          end else begin
            runes_left = digits_acc;
            res = record_fields(KIND_HEADER);
            digits_acc = '0;
            ph = (runes_left == 0) ? PH_NEWLINE : PH_LEAD;
          end
        end else begin
          if (ph == PH_START) rec_start = digits_acc;
          else if (ph == PH_END) rec_end = digits_acc;
          else rec_flags = digits_acc;
          digits_acc = '0;
          ph = phase_t'(ph + 1);
        end
      end
      PH_LEAD, PH_CONT: begin
        has_res = 1'b1;
        if (beat.stream_end) begin
          res = parse_error(ERR_EARLY_END);
        end else begin
          res = record_fields(KIND_TEXT);
          res.text_byte = b;
          if (ph == PH_LEAD) begin
            if (b < UTF_TWO) begin
              res.rune_done = 1'b1;
              finish_rune();
            end else begin
              rune_bytes_left = (b < UTF_THREE) ? 2'd1 : (b < UTF_FOUR) ? 2'd2 : 2'd3;
              ph = PH_CONT;
            end
          end else begin
            rune_bytes_left = rune_bytes_left - 1'b1;
            if (rune_bytes_left == 0) begin
              res.rune_done = 1'b1;
              finish_rune();
            end
          end
        end
      end
      PH_NEWLINE: begin
        has_res = 1'b1;
        if (beat.stream_end || b != CH_LF) begin
          res = parse_error(ERR_NO_NEWLINE);
        end else begin
          res = record_fields(KIND_END);
          ph = PH_FIRST;
        end
      end
      default: ph = PH_STOP;
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic fin);
    tevp_in_t  beat;
    logic      has_res;
    tevp_out_t res;
    int        gap;
    if (idle_enabled) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    beat.byte_in = b;
    beat.stream_end = fin;
    item <= beat;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    parse_byte(beat, has_res, res);
    if (has_res) pending_results.push_back(res);
    beats_in++;
  endtask

  task automatic wait_results_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  function automatic string random_number_text();
    string s;
    int    n;
    case ($urandom_range(0, 9))
      0: s = "";
      1: begin
        s = "";
        n = $urandom_range(10, 14);
        repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      2: s = "2147483647";
      3: s = "2147483648";
      4, 5: s = $sformatf("%0d", $urandom);
      default: s = $sformatf("%0d", $urandom_range(0, 9999));
    endcase
    if ($urandom_range(0, 7) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic string count_text(int n);
    if (n == 0 && $urandom_range(0, 1) == 0) return "";
    if ($urandom_range(0, 5) == 0) return $sformatf("0%0d", n);
    return $sformatf("%0d", n);
  endfunction

  function automatic int random_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 6);
    if (pick < 95) return $urandom_range(7, 40);
    return $urandom_range(100, MAX_RUNES - 1);
  endfunction

  task automatic send_field(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    send_beat(CH_SPACE, 1'b0);
  endtask

  task automatic send_prefix(int fields);
    send_beat(8'($urandom_range(0, 255)), 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b0);
    repeat (fields) send_field(random_number_text());
  endtask

  task automatic send_runes(int n);
    int len;
    repeat (n) begin
      len = $urandom_range(1, 4);
      case (len)
        1: send_beat(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
        2: send_beat(8'($urandom_range(8'h80, 8'hDF)), 1'b0);
        3: send_beat(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
        default: send_beat(8'($urandom_range(8'hF0, 8'hFF)), 1'b0);
      endcase
      repeat (len - 1) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic send_record(int n);
    send_prefix(3);
    send_field(count_text(n));
    send_runes(n);
    send_beat(CH_LF, 1'b0);
    records_sent++;
  endtask

  task automatic test_empty_fields();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    repeat (4) send_beat(CH_SPACE, 1'b0);
    send_beat(CH_LF, 1'b0);
    records_sent++;
  endtask

  task automatic test_saturation_and_rune_lengths();
    logic [7:0] text[10] = '{8'h7F, 8'h80, 8'hFF, 8'hEF, 8'h00, 8'hC0,
                             8'hF0, 8'h41, 8'h0A, 8'h20};
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_field("2147483648");
    send_field("");
    send_field("9");
    send_field("4");
    foreach (text[i]) send_beat(text[i], 1'b0);
    send_beat(CH_LF, 1'b0);
    records_sent++;
  endtask

  task automatic test_full_count();
    wait_results_drained();
    send_record(MAX_RUNES - 1);
  endtask

  task automatic test_random_records();
    int unsigned next_pause;
    next_pause = beats_in + 300;
    while (beats_in < 1600) begin
      idle_enabled = ($urandom_range(0, 3) != 0);
      send_record(random_count());
      if (beats_in >= next_pause) begin
        wait_results_drained();
        next_pause = beats_in + $urandom_range(200, 500);
      end
    end
    idle_enabled = 1'b1;
  endtask

  task automatic test_stream_stop();
    logic [7:0] b;
    int         n;
    stop_case = $urandom_range(0, 7);
    case (stop_case)
      0: send_beat(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      2, 3: begin
        send_prefix($urandom_range(0, 3));
        repeat ($urandom_range(0, 3)) send_beat(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        if (stop_case == 2) begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_SPACE || (b >= CH_ZERO && b <= CH_NINE));
          send_beat(b, 1'b0);
        end
      end
      4: begin
        send_prefix(3);
        case ($urandom_range(0, 2))
          0: send_field($sformatf("%0d", MAX_RUNES));
          1: send_field($sformatf("%0d", $urandom_range(MAX_RUNES + 1, 99999)));
          default: send_field("99999999999");
        endcase
      end
      5: begin
        n = $urandom_range(1, 5);
        send_prefix(3);
        send_field(count_text(n));
        send_runes($urandom_range(0, n - 1));
        if ($urandom_range(0, 1) == 0) send_beat(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        n = $urandom_range(0, 4);
        send_prefix(3);
        send_field(count_text(n));
        send_runes(n);
        if (stop_case == 6) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
          send_beat(b, 1'b0);
        end else begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end
      end
    endcase
    repeat (16) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    stall_clock++;
    if (stall_clock % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 3) != 0);
      2: result_ready <= ($urandom_range(0, 9) < 3);
      default: result_ready <= stall_clock[3] | stall_clock[0];
    endcase
  end

  task automatic note_mismatch(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s at %0t ns: expected %0h, got %0h", field, $realtime, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result beat, kind", '0, result.result_kind);
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.result_kind !== oldest_result.result_kind)
          note_mismatch("result_kind", oldest_result.result_kind, result.result_kind);
        if (result.origin_char !== oldest_result.origin_char)
          note_mismatch("origin_char", oldest_result.origin_char, result.origin_char);
        if (result.type_char !== oldest_result.type_char)
          note_mismatch("type_char", oldest_result.type_char, result.type_char);
        if (result.start_pos !== oldest_result.start_pos)
          note_mismatch("start_pos", oldest_result.start_pos, result.start_pos);
        if (result.end_pos !== oldest_result.end_pos)
          note_mismatch("end_pos", oldest_result.end_pos, result.end_pos);
        if (result.flag_bits !== oldest_result.flag_bits)
          note_mismatch("flag_bits", oldest_result.flag_bits, result.flag_bits);
        if (result.rune_count !== oldest_result.rune_count)
          note_mismatch("rune_count", oldest_result.rune_count, result.rune_count);
        if (result.text_byte !== oldest_result.text_byte)
          note_mismatch("text_byte", oldest_result.text_byte, result.text_byte);
        if (result.rune_done !== oldest_result.rune_done)
          note_mismatch("rune_done", oldest_result.rune_done, result.rune_done);
        if (result.error_code !== oldest_result.error_code)
          note_mismatch("error_code", oldest_result.error_code, result.error_code);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, pending_results.size());
          $display("FAIL text_event_record_parser_core");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_fields();
    test_saturation_and_rune_lengths();
    test_full_count();
    test_random_records();
    test_stream_stop();
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d byte beats in %0d whole records and checked %0d result beats.",
             beats_in, records_sent, beats_out);
    $display("Stream stopped by: %s; %0d mismatches.", stop_names[stop_case], mismatches);
    if (mismatches == 0) begin
      $display("PASS text_event_record_parser_core");
    end else begin
      $display("FAIL text_event_record_parser_core");
    end
    $finish;
  end

endmodule

// ===== text_event_record_parser_core.f =====
rtl/tevp_pkg.sv
rtl/tevp_parser.sv
rtl/tevp_out_reg.sv
rtl/text_event_record_parser_core.sv
rtl/tevp_checker.sv
sim/text_event_record_parser_core_test.sv
